// File: src/fvu_pkg.sv
// Shared types, constants and helpers for the finite-volume Euler update block.
package fvu_pkg;

	localparam int unsigned CELL_COUNT_DEF = 4096;
	localparam int unsigned IDX_W          = 12;
	localparam int unsigned NVALS          = 5;
	localparam int unsigned QDEPTH         = 4;
	localparam int unsigned DIV_STEPS      = 48;
	localparam logic [31:0] SCALE_DT_RESET = 32'h0001_0000;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_FACE_INT = 2'd1,
		OP_FACE_BND = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	// queued item, already classified by the front end
	typedef struct packed {
		op_t                    op;
		logic                   own_ok;
		logic                   nbr_ok;
		logic [IDX_W-1:0]       own;
		logic [IDX_W-1:0]       nbr;
		word_t                  area;
		word_t [NVALS-1:0]      val;
		word_t                  vol;
		word_t                  ts;
	} item_t;

	typedef struct packed {
		word_t [NVALS-1:0] val;
		word_t             vol;
		word_t             ts;
	} cell_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_READ,
		B_RES,
		B_DT,
		B_G,
		B_DIVGO,
		B_DIV,
		B_MUL,
		B_ACC,
		B_WRITE
	} bstate_t;

	typedef struct packed {
		logic        start;
		logic [47:0] dividend;
		word_t       divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t quot;
	} div_rsp_t;

	// product bits [63:16] clamped to unsigned 32 bits
	function automatic word_t sat_u32(input logic [47:0] v);
		return (v[47:32] != 16'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

// File: src/fvu_front.sv
// Input side: accepts items, checks cell indices, queues them for the back end.
module fvu_front
	import fvu_pkg::*;
#(
	parameter int unsigned CELL_COUNT = CELL_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       operation,
	input  logic [IDX_W-1:0] owner_cell,
	input  logic [IDX_W-1:0] neighbour_cell,
	input  word_t            face_area,
	input  word_t            rho_value,
	input  word_t            mx_value,
	input  word_t            my_value,
	input  word_t            mz_value,
	input  word_t            energy_value,
	input  word_t            cell_volume,
	input  word_t            cell_time_step,
	output logic             q_valid,
	output item_t            q_item,
	input  logic             q_pop
);
	localparam int unsigned PW = $clog2(QDEPTH);
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	item_t          fifo_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	item_t          new_item;
	logic           push;

	always_comb begin
		new_item        = '0;
		new_item.op     = op_t'(operation);
		new_item.own_ok = (32'(owner_cell) < 32'(CELL_COUNT));
		new_item.nbr_ok = (32'(neighbour_cell) < 32'(CELL_COUNT));
		new_item.own    = owner_cell;
		new_item.nbr    = neighbour_cell;
		new_item.area   = face_area;
		new_item.val[0] = rho_value;
		new_item.val[1] = mx_value;
		new_item.val[2] = my_value;
		new_item.val[3] = mz_value;
		new_item.val[4] = energy_value;
		new_item.vol    = cell_volume;
		new_item.ts     = cell_time_step;
	end

	assign in_stall = (cnt_q == CW'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QDEPTH)) else $error("queue count overflow");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");
`endif

endmodule

// File: src/fvu_div.sv
// Restoring divider, one quotient bit per cycle, result clamped to 32 bits.
module fvu_div
	import fvu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [47:0] num_q, quot_q;
	word_t       rem_q, den_q;
	logic [32:0] rem_sh, rem_sub;

	assign rem_sh  = {rem_q, num_q[47]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			den_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], 1'b0};
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q  <= rem_sub[31:0];
				quot_q <= {quot_q[46:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[31:0];
				quot_q <= {quot_q[46:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sat_u32(quot_q);

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
`endif

endmodule

// File: src/fvu_back.sv
// Execution side: cell memory, face update sequencer and the result register.
module fvu_back
	import fvu_pkg::*;
#(
	parameter int unsigned CELL_COUNT = CELL_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  word_t            scale_dt,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] cell_index,
	output word_t            density,
	output word_t            momentum_x_out,
	output word_t            momentum_y_out,
	output word_t            momentum_z_out,
	output word_t            energy
);
	localparam int unsigned AW = $clog2(CELL_COUNT);

	cell_t            mem [CELL_COUNT];
	cell_t            rd_q, wr_data;
	logic             mem_we;
	logic [AW-1:0]    wr_addr, cur_addr;
	logic [31:0]      wr_idx32, cur_idx32;

	bstate_t          state_q, state_d;
	item_t            item_q;
	logic             side_q;          // 0 owner, 1 neighbour
	logic [2:0]       k_q;
	logic [63:0]      prod_q;
	word_t            r_q;
	word_t [NVALS-1:0] vals_q;

	div_req_t         dreq;
	div_rsp_t         drsp;

	logic             out_free, out_load;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	word_t [NVALS-1:0] out_val_q;

	word_t            flux, mag, old;
	logic             neg, subtract;
	logic [49:0]      vsum;
	word_t            vsat;

	fvu_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign out_free  = !out_valid_q || !out_stall;
	assign cur_idx32 = 32'(side_q ? item_q.nbr : item_q.own);
	assign cur_addr  = cur_idx32[AW-1:0];

	// one face-side value update
	assign flux     = item_q.val[k_q];
	assign neg      = flux[31];
	assign mag      = neg ? (32'd0 - flux) : flux;
	assign old      = vals_q[k_q];
	assign subtract = !side_q;
	always_comb begin
		if (neg != subtract)
			vsum = {{18{old[31]}}, old} - {2'b00, prod_q[63:16]};
		else
			vsum = {{18{old[31]}}, old} + {2'b00, prod_q[63:16]};
		if (!vsum[49] && (vsum[48:31] != '0))
			vsat = 32'h7FFF_FFFF;
		else if (vsum[49] && (vsum[48:31] != '1))
			vsat = 32'h8000_0000;
		else
			vsat = vsum[31:0];
	end

	always_comb begin
		state_d       = state_q;
		q_pop         = 1'b0;
		mem_we        = 1'b0;
		wr_idx32      = 32'(q_item.own);
		wr_data.val   = q_item.val;
		wr_data.vol   = q_item.vol;
		wr_data.ts    = q_item.ts;
		dreq.start    = 1'b0;
		dreq.dividend = {sat_u32(prod_q[63:16]), 16'd0};
		dreq.divisor  = rd_q.vol;
		out_load      = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_item.op)
						OP_LOAD: mem_we = q_item.own_ok;
						OP_READ: state_d = q_item.own_ok ? B_READ : B_RES;
						OP_FACE_INT: begin
							if (q_item.own_ok || q_item.nbr_ok) state_d = B_READ;
						end
						OP_FACE_BND: begin
							if (q_item.own_ok) state_d = B_READ;
						end
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_READ: state_d = (item_q.op == OP_READ) ? B_RES : B_DT;
			B_RES: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			B_DT:    state_d = B_G;
			B_G:     state_d = B_DIVGO;
			B_DIVGO: begin
				if (rd_q.vol == '0) begin
					state_d = B_MUL;
				end else begin
					dreq.start = 1'b1;
					state_d    = B_DIV;
				end
			end
			B_DIV: begin
				if (drsp.done) state_d = B_MUL;
			end
			B_MUL: state_d = B_ACC;
			B_ACC: state_d = (k_q == 3'(NVALS - 1)) ? B_WRITE : B_MUL;
			B_WRITE: begin
				mem_we      = 1'b1;
				wr_idx32    = cur_idx32;
				wr_data.val = vals_q;
				wr_data.vol = rd_q.vol;
				wr_data.ts  = rd_q.ts;
				if (!side_q && (item_q.op == OP_FACE_INT) && item_q.nbr_ok)
					state_d = B_READ;
				else
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign wr_addr = wr_idx32[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (state_q == B_READ) rd_q <= mem[cur_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				item_q <= q_item;
				// internal face with a bad owner goes straight to the neighbour
				side_q <= !q_item.own_ok;
			end
			B_DT: begin
				vals_q <= rd_q.val;
				prod_q <= 64'(scale_dt) * 64'(rd_q.ts);
			end
			B_G:     prod_q <= 64'(sat_u32(prod_q[63:16])) * 64'(item_q.area);
			B_DIVGO: begin
				r_q <= '0;
				k_q <= '0;
			end
			B_DIV: begin
				if (drsp.done) r_q <= drsp.quot;
			end
			B_MUL: prod_q <= 64'(r_q) * 64'(mag);
			B_ACC: begin
				vals_q[k_q] <= vsat;
				k_q         <= k_q + 1'b1;
			end
			B_WRITE: side_q <= 1'b1;
			default: ;
		endcase
		if (out_load) begin
			out_idx_q <= item_q.own;
			out_val_q <= item_q.own_ok ? rd_q.val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign cell_index     = out_idx_q;
	assign density        = out_val_q[0];
	assign momentum_x_out = out_val_q[1];
	assign momentum_y_out = out_val_q[2];
	assign momentum_z_out = out_val_q[3];
	assign energy         = out_val_q[4];

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == B_IDLE) else $error("pop outside idle");
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == B_IDLE || state_q == B_WRITE)) else $error("stray write");
	a_done_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == B_DIV) else $error("divider done unexpected");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("result overwritten");
`endif

endmodule

// File: src/finite_volume_euler_update_top.sv
// Top level of the finite-volume explicit Euler cell update block.
// Items enter on in_valid/in_stall and sit in a four-entry queue, so the
// source keeps streaming while the execution side works, until the queue is
// full. A boundary face runs the update sequence for its one side. An internal
// face runs the same sequence for the owner and then the neighbour, skipping
// a side whose cell index is out of range. The sequence is a cell read, two
// multiply steps for dt and g, a 48-step restoring division by the volume,
// five multiply/accumulate pairs on the conserved values, and the write back.
// A zero volume skips the division. Reads deliver one item on
// out_valid/out_stall through a result register; loads and faces deliver
// none. Cell storage is not cleared at reset: read only cells that were
// loaded. scale_dt may be written only while the block is idle.
module finite_volume_euler_update_top
	import fvu_pkg::*;
#(
	parameter int unsigned CELL_COUNT = CELL_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             scale_dt_we,
	input  word_t            scale_dt_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       operation,
	input  logic [IDX_W-1:0] owner_cell,
	input  logic [IDX_W-1:0] neighbour_cell,
	input  word_t            face_area,
	input  word_t            rho_value,
	input  word_t            mx_value,
	input  word_t            my_value,
	input  word_t            mz_value,
	input  word_t            energy_value,
	input  word_t            cell_volume,
	input  word_t            cell_time_step,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] cell_index,
	output word_t            density,
	output word_t            momentum_x_out,
	output word_t            momentum_y_out,
	output word_t            momentum_z_out,
	output word_t            energy
);
	word_t scale_dt_q;
	logic  q_valid, q_pop;
	item_t q_item;

	// time step scale register, 1.0 after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scale_dt_q <= SCALE_DT_RESET;
		else if (scale_dt_we) scale_dt_q <= scale_dt_wdata;
	end

	fvu_front #(.CELL_COUNT(CELL_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .owner_cell(owner_cell), .neighbour_cell(neighbour_cell),
		.face_area(face_area), .rho_value(rho_value), .mx_value(mx_value),
		.my_value(my_value), .mz_value(mz_value), .energy_value(energy_value),
		.cell_volume(cell_volume), .cell_time_step(cell_time_step),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	fvu_back #(.CELL_COUNT(CELL_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .scale_dt(scale_dt_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .cell_index(cell_index),
		.density(density), .momentum_x_out(momentum_x_out),
		.momentum_y_out(momentum_y_out), .momentum_z_out(momentum_z_out),
		.energy(energy)
	);

endmodule
